/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH     = 16;
   localparam int DEFAULT_PRIORITY_LEVELS = 8;
   localparam int DEFAULT_SEQUENCE_BITS   = 32;

   // request op codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;

   // result status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_POPPED   = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_FLUSHED  = 3'd4;

   // command kinds between front and back
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  priority_req;
      logic [15:0] task_tag;
      logic [7:0]  token_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_task_tag;
      logic [7:0]  out_token_tag;
      logic [2:0]  out_priority;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  prio;
      logic [15:0] task_tag;
      logic [7:0]  token_tag;
   } cmd_type;

endpackage

/* hdl/spq_front.sv */
`timescale 1ns / 1ps

module spq_front #(
   parameter int PRIORITY_LEVELS = spq_pkg::DEFAULT_PRIORITY_LEVELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output spq_pkg::cmd_type cmd_data
);

   spq_pkg::cmd_type cls;
   spq_pkg::cmd_type buf_ff [2];
   logic [1:0]       fill_ff, fill_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic             push, pull;

   // classify: high op bit means flush, priority saturates to the top level
   always_comb begin
      cls.task_tag  = req_data.task_tag;
      cls.token_tag = req_data.token_tag;
      if (req_data.op[1]) begin
         cls.kind = spq_pkg::CMD_FLUSH;
      end else if (req_data.op == spq_pkg::OP_INSERT) begin
         cls.kind = spq_pkg::CMD_INSERT;
      end else begin
         cls.kind = spq_pkg::CMD_POP;
      end
      if (int'(req_data.priority_req) >= PRIORITY_LEVELS) begin
         cls.prio = 3'(PRIORITY_LEVELS - 1);
      end else begin
         cls.prio = req_data.priority_req;
      end
   end

   // two-beat queue towards the back end
   assign req_ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data  = buf_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pull      = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pull ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pull);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* hdl/spq_back.sv */
`timescale 1ns / 1ps

module spq_back #(
   parameter int QUEUE_DEPTH     = spq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIORITY_LEVELS = spq_pkg::DEFAULT_PRIORITY_LEVELS,
   parameter int SEQUENCE_BITS   = spq_pkg::DEFAULT_SEQUENCE_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  spq_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   localparam int IW     = $clog2(QUEUE_DEPTH);
   localparam int LVL    = IW;
   localparam int P      = 1 << LVL;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int SW     = $clog2(LVL + 1);
   localparam int PW_RAW = $clog2(PRIORITY_LEVELS);
   localparam int PW     = (PW_RAW < 3) ? PW_RAW : 3;
   localparam int SB     = SEQUENCE_BITS;

   // entry store
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [PW-1:0]          prio_ff  [QUEUE_DEPTH];
   logic [SB-1:0]          seq_ff   [QUEUE_DEPTH];
   logic [15:0]            task_ff  [QUEUE_DEPTH];
   logic [7:0]             token_ff [QUEUE_DEPTH];
   logic [SB-1:0]          next_seq_ff, next_seq_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SW-1:0]          settle_ff, settle_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type       rsp_ff, rsp_in;

   // compare tree, heap order: node n takes nodes 2n and 2n+1
   logic          lf_valid [P];
   logic [PW-1:0] lf_prio  [P];
   logic [SB-1:0] lf_seq   [P];
   logic [IW-1:0] lf_idx   [P];
   logic          nd_valid_ff [1:P-1];
   logic [PW-1:0] nd_prio_ff  [1:P-1];
   logic [SB-1:0] nd_seq_ff   [1:P-1];
   logic [IW-1:0] nd_idx_ff   [1:P-1];

   logic          free_found;
   logic [IW-1:0] free_idx;
   logic          out_free, take;
   logic          best_valid;
   logic [IW-1:0] best_idx;

   for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i < QUEUE_DEPTH) begin : g_real
         assign lf_valid[i] = valid_ff[i];
         assign lf_prio[i]  = prio_ff[i];
         assign lf_seq[i]   = seq_ff[i];
      end else begin : g_pad
         assign lf_valid[i] = 1'b0;
         assign lf_prio[i]  = '0;
         assign lf_seq[i]   = '0;
      end
      assign lf_idx[i] = IW'(i);
   end

   for (genvar n = 1; n < P; n++) begin : g_node
      logic          a_v, b_v, take_b;
      logic [PW-1:0] a_p, b_p;
      logic [SB-1:0] a_s, b_s, diff;
      logic [IW-1:0] a_i, b_i;

      if (n >= P / 2) begin : g_bottom
         assign a_v = lf_valid[2*n-P];
         assign a_p = lf_prio[2*n-P];
         assign a_s = lf_seq[2*n-P];
         assign a_i = lf_idx[2*n-P];
         assign b_v = lf_valid[2*n+1-P];
         assign b_p = lf_prio[2*n+1-P];
         assign b_s = lf_seq[2*n+1-P];
         assign b_i = lf_idx[2*n+1-P];
      end else begin : g_inner
         assign a_v = nd_valid_ff[2*n];
         assign a_p = nd_prio_ff[2*n];
         assign a_s = nd_seq_ff[2*n];
         assign a_i = nd_idx_ff[2*n];
         assign b_v = nd_valid_ff[2*n+1];
         assign b_p = nd_prio_ff[2*n+1];
         assign b_s = nd_seq_ff[2*n+1];
         assign b_i = nd_idx_ff[2*n+1];
      end

      // wrap-aware age: b older than a when the top bit of b - a is set
      assign diff   = b_s - a_s;
      assign take_b = b_v && (!a_v || (b_p < a_p) || ((b_p == a_p) && diff[SB-1]));

      always_ff @(posedge clock) begin
         nd_valid_ff[n] <= take_b ? b_v : a_v;
         nd_prio_ff[n]  <= take_b ? b_p : a_p;
         nd_seq_ff[n]   <= take_b ? b_s : a_s;
         nd_idx_ff[n]   <= take_b ? b_i : a_i;
      end
   end

   assign best_valid = nd_valid_ff[1];
   assign best_idx   = nd_idx_ff[1];

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // a pop waits until the tree has settled on the current entries
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = out_free && ((cmd_data.kind != spq_pkg::CMD_POP) || (settle_ff == '0));
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      next_seq_in  = next_seq_ff;
      settle_in    = (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         unique case (cmd_data.kind)
            spq_pkg::CMD_FLUSH: begin
               valid_in      = '0;
               count_in      = '0;
               settle_in     = SW'(LVL);
               rsp_in.status = spq_pkg::ST_FLUSHED;
            end
            spq_pkg::CMD_INSERT: begin
               if (free_found) begin
                  valid_in[free_idx] = 1'b1;
                  count_in           = count_ff + 1'b1;
                  next_seq_in        = next_seq_ff + 1'b1;
                  settle_in          = SW'(LVL);
                  rsp_in.status      = spq_pkg::ST_INSERTED;
               end else begin
                  rsp_in.status = spq_pkg::ST_FULL;
               end
            end
            default: begin
               if (best_valid) begin
                  valid_in[best_idx]   = 1'b0;
                  count_in             = count_ff - 1'b1;
                  settle_in            = SW'(LVL);
                  rsp_in.status        = spq_pkg::ST_POPPED;
                  rsp_in.out_task_tag  = task_ff[best_idx];
                  rsp_in.out_token_tag = token_ff[best_idx];
                  rsp_in.out_priority  = 3'(nd_prio_ff[1]);
               end else begin
                  rsp_in.status = spq_pkg::ST_EMPTY;
               end
            end
         endcase
         rsp_in.occupancy = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         next_seq_ff  <= '0;
         settle_ff    <= SW'(LVL);
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (take && (cmd_data.kind == spq_pkg::CMD_INSERT) && free_found) begin
         prio_ff[free_idx]  <= PW'(cmd_data.prio);
         seq_ff[free_idx]   <= next_seq_ff;
         task_ff[free_idx]  <= cmd_data.task_tag;
         token_ff[free_idx] <= cmd_data.token_tag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/stable_priority_task_queue.sv */
`timescale 1ns / 1ps

// channel  ports                          payload
// request  req_valid req_ready req_data   spq_pkg::req_type (op, priority, task, token)
// result   rsp_valid rsp_ready rsp_data   spq_pkg::rsp_type (status, tags, priority, count)
//
// One result beat per request beat, in order. A two-beat queue sits between the
// classifying front end and the back end that owns the entries.
// Inserts and flushes do not wait for the compare tree. Any pop waits for the tree to settle
// after the last change to the entries (a pop that removed an entry included), so a pop straight
// after a change is held until the settle count runs out. Synchronous reset clears valid bits,
// count and sequence and restarts the settle count; no clearing pass. Either side may stall;
// the result register holds.
module stable_priority_task_queue #(
   parameter int QUEUE_DEPTH     = spq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIORITY_LEVELS = spq_pkg::DEFAULT_PRIORITY_LEVELS,
   parameter int SEQUENCE_BITS   = spq_pkg::DEFAULT_SEQUENCE_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   logic             cmd_valid;
   logic             cmd_ready;
   spq_pkg::cmd_type cmd_data;

   spq_front #(
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   spq_back #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .SEQUENCE_BITS   (SEQUENCE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb_stable_priority_task_queue.sv */
`timescale 1ns / 1ps

module tb_stable_priority_task_queue;

   localparam int DEPTH    = spq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int LEVELS   = spq_pkg::DEFAULT_PRIORITY_LEVELS;
   localparam int SEQ_BITS = spq_pkg::DEFAULT_SEQUENCE_BITS;

   // both codes with the high bit set clear the queue
   localparam logic [1:0] OP_FLUSH    = 2'd2;
   localparam logic [1:0] OP_FLUSH_HI = 2'd3;

   localparam int N_RANDOM    = 600;
   localparam int PHASE_LEN   = 40;
   localparam int HOLD_AFTER  = 120;
   localparam int HOLD_CYCLES = 100;

   // ---------------------------------------------------------------
   class task_queue_checker;
      bit                  slot_valid [DEPTH];
      logic [2:0]          slot_prio  [DEPTH];
      logic [SEQ_BITS-1:0] slot_seq   [DEPTH];
      logic [15:0]         slot_task  [DEPTH];
      logic [7:0]          slot_token [DEPTH];
      logic [SEQ_BITS-1:0] next_seq;
      int unsigned         held;
      spq_pkg::rsp_type    replies_due [$];
      int unsigned         errors;
      int unsigned         status_count [5];

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         foreach (status_count[i]) status_count[i] = 0;
         next_seq = '0;
         held     = 0;
         errors   = 0;
      endfunction

      // wrap-aware: a is older than b when a - b has its top bit set
      function bit seq_older(logic [SEQ_BITS-1:0] a, logic [SEQ_BITS-1:0] b);
         logic [SEQ_BITS-1:0] diff;
         diff = a - b;
         return diff[SEQ_BITS-1];
      endfunction

      function bit goes_first(int a, int b);
         if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
         return seq_older(slot_seq[a], slot_seq[b]);
      endfunction

      function spq_pkg::rsp_type apply_op(spq_pkg::req_type r);
         spq_pkg::rsp_type res;
         logic [2:0]       prio;
         int               pick;
         res  = '0;
         prio = (r.priority_req >= LEVELS) ? 3'(LEVELS - 1) : r.priority_req;
         pick = -1;
         if (r.op[1]) begin
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            held       = 0;
            res.status = spq_pkg::ST_FLUSHED;
         end else if (r.op == spq_pkg::OP_INSERT) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!slot_valid[i]) begin
                  pick = i;
                  break;
               end
            end
            if (pick < 0) begin
               res.status = spq_pkg::ST_FULL;
            end else begin
               slot_valid[pick] = 1'b1;
               slot_prio[pick]  = prio;
               slot_seq[pick]   = next_seq;
               slot_task[pick]  = r.task_tag;
               slot_token[pick] = r.token_tag;
               next_seq         = next_seq + 1'b1;
               held++;
               res.status = spq_pkg::ST_INSERTED;
            end
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_valid[i] && (pick < 0 || goes_first(i, pick))) pick = i;
            end
            if (pick < 0) begin
               res.status = spq_pkg::ST_EMPTY;
            end else begin
               res.out_task_tag  = slot_task[pick];
               res.out_token_tag = slot_token[pick];
               res.out_priority  = slot_prio[pick];
               slot_valid[pick]  = 1'b0;
               if (held > 0) held--;
               res.status = spq_pkg::ST_POPPED;
            end
         end
         res.occupancy = 5'(held);
         return res;
      endfunction

      function void note_request(spq_pkg::req_type r);
         spq_pkg::rsp_type res;
         res = apply_op(r);
         status_count[res.status]++;
         replies_due.insert(replies_due.size(), res);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_reply(spq_pkg::rsp_type got);
         spq_pkg::rsp_type want;
         if (replies_due.size() == 0) begin
            $error("result beat with nothing outstanding: %h", got);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("out_task_tag", want.out_task_tag, got.out_task_tag);
         compare_field("out_token_tag", 16'(want.out_token_tag), 16'(got.out_token_tag));
         compare_field("out_priority", 16'(want.out_priority), 16'(got.out_priority));
         compare_field("occupancy", 16'(want.occupancy), 16'(got.occupancy));
      endfunction

      function int outstanding();
         return replies_due.size();
      endfunction
   endclass

   // ---------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   spq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   spq_pkg::rsp_type rsp_data;

   task_queue_checker sb = new();
   bit                send_no_idle;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stable_priority_task_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // entered and left at a falling edge
   task automatic send_req(input spq_pkg::req_type r);
      int gap;
      gap = send_no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   function automatic spq_pkg::req_type make_req(logic [1:0] op, logic [2:0] prio,
                                                 logic [15:0] tsk, logic [7:0] tok);
      spq_pkg::req_type r;
      r.op           = op;
      r.priority_req = prio;
      r.task_tag     = tsk;
      r.token_tag    = tok;
      return r;
   endfunction

   // mode 0 fills, 1 drains, 2 roughly balanced
   function automatic spq_pkg::req_type random_req(int mode);
      spq_pkg::req_type r;
      int               roll;
      int               insert_pct;
      r          = make_req(spq_pkg::OP_POP, 3'($urandom_range(0, 7)),
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      roll       = $urandom_range(0, 99);
      insert_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 55;
      if (roll < 2) r.op = $urandom_range(0, 1) ? OP_FLUSH : OP_FLUSH_HI;
      else if (roll < insert_pct) r.op = spq_pkg::OP_INSERT;
      return r;
   endfunction

   // result side: random stalls, quiet stretches, and one long hold-off
   initial begin
      int gap;
      int beats;
      bit quiet;
      bit hold_done;
      beats     = 0;
      quiet     = 1'b0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (beats % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
         gap = quiet ? 0 : $urandom_range(0, 6);
         if (!hold_done && beats >= HOLD_AFTER) begin
            hold_done = 1'b1;
            gap       = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_reply(rsp_data);
         beats++;
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for results");
      $display("status: fail");
      $finish;
   end

   initial begin
      int mode;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      send_no_idle = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, fill with extremes and ties, overflow, both flush codes
      send_req(make_req(spq_pkg::OP_POP, 3'd0, 16'h0000, 8'h00));
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0)
            send_req(make_req(spq_pkg::OP_INSERT, 3'd0, 16'h0000, 8'h00));
         else if (i == 1)
            send_req(make_req(spq_pkg::OP_INSERT, 3'd7, 16'hffff, 8'hff));
         else
            send_req(make_req(spq_pkg::OP_INSERT, 3'($urandom_range(0, 7)),
                              16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
      end
      send_req(make_req(spq_pkg::OP_INSERT, 3'd3, 16'h5a5a, 8'ha5));
      send_req(make_req(spq_pkg::OP_POP, 3'd7, 16'hffff, 8'hff));
      send_req(make_req(spq_pkg::OP_POP, 3'd0, 16'h0000, 8'h00));
      send_req(make_req(OP_FLUSH, 3'd0, 16'h0000, 8'h00));
      send_req(make_req(spq_pkg::OP_INSERT, 3'd5, 16'h1234, 8'h56));
      send_req(make_req(OP_FLUSH_HI, 3'd7, 16'hffff, 8'hff));
      send_req(make_req(spq_pkg::OP_POP, 3'd0, 16'h0000, 8'h00));

      mode = 0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % PHASE_LEN == 0) begin
            mode         = $urandom_range(0, 2);
            send_no_idle = ($urandom_range(0, 3) == 0);
         end
         send_req(random_req(mode));
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d inserts, %0d full rejects, %0d pops, %0d empty pops,",
               sb.status_count[spq_pkg::ST_INSERTED], sb.status_count[spq_pkg::ST_FULL],
               sb.status_count[spq_pkg::ST_POPPED], sb.status_count[spq_pkg::ST_EMPTY]);
      $display("%0d flushes, with one long result hold-off; mismatches seen: %0d",
               sb.status_count[spq_pkg::ST_FLUSHED], sb.errors);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
